>>> sv/hmp_pkg.sv
// Package for the HMP track to Standard MIDI transcoder.
// Holds shared constants, length tables and the controller/datapath structs.
// Depends on nothing.
package hmp_pkg;

    localparam int unsigned MAX_DELTA_BYTES_DEF = 4;

    // Burst length counter: up to seven output bytes per input item.
    localparam int unsigned BURST_W = 3;
    localparam logic [BURST_W-1:0] TEMPO_BURST_LEN = BURST_W'(7);

    // Tempo division: 120000000 fits in 27 bits, so the quotient does too.
    localparam int unsigned DIVIDEND_W = 27;
    localparam logic [DIVIDEND_W-1:0] TEMPO_DIVIDEND = DIVIDEND_W'(120000000);
    localparam logic [23:0] TEMPO_ZERO_DIV = 24'hFFFFFF;
    localparam logic [31:0] HEADER_TEMPO_RESET = 32'd240;

    // Tempo meta event bytes.
    localparam logic [7:0] DELTA_ZERO     = 8'h00;
    localparam logic [7:0] META_STATUS    = 8'hFF;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_TEMPO_LEN = 8'h03;

    // Status byte decoding.
    localparam logic [3:0] STATUS_HI_SYSTEM = 4'hF;
    localparam logic [3:0] STATUS_HI_CTRL   = 4'hB;
    localparam logic [3:0] SYS_LO_SYSEX     = 4'h0;
    localparam logic [3:0] SYS_LO_META      = 4'hF;

    // Controller rewriting.
    localparam logic [7:0] CTRL_MAP_LO      = 8'd102;
    localparam logic [7:0] CTRL_MAP_HI      = 8'd119;
    localparam logic [7:0] CTRL_LOOP_START  = 8'd110;
    localparam logic [7:0] CTRL_LOOP_END    = 8'd111;
    localparam logic [7:0] EMIDI_LOOP_START = 8'd118;
    localparam logic [7:0] EMIDI_LOOP_END   = 8'd119;
    localparam logic [7:0] CTRL_MAX_VALUE   = 8'd127;
    localparam logic [7:0] CTRL_NEUTRAL     = 8'd102;
    localparam logic [7:0] CTRL_ZERO_VALUE  = 8'd0;

    // Event length by status bits 6:4. Zero means the status has no data length.
    function automatic logic [1:0] cmd_len(input logic [2:0] idx);
        logic [1:0] len;
        unique case (idx)
            3'd4, 3'd5: len = 2'd1;
            3'd7:       len = 2'd0;
            default:    len = 2'd2;
        endcase
        return len;
    endfunction

    // Data length of the system common messages by the low status nibble.
    function automatic logic [1:0] syscom_len(input logic [3:0] lo);
        logic [1:0] len;
        unique case (lo)
            4'h2:    len = 2'd2;
            4'h3:    len = 2'd1;
            default: len = 2'd0;
        endcase
        return len;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // input transfer accepted this cycle
        logic emit;   // load the next burst byte into the output register
        logic last;   // that byte is the last of the burst
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [BURST_W-1:0] burst_len; // bytes caused by the offered input item
        logic               div_req;   // the offered item needs the tempo division
        logic               div_done;  // the tempo quotient is ready
        logic               out_free;  // the output register can take a byte
    } t_dp_status;

endpackage

>>> sv/hmp_if.sv
// Valid/ready channel interfaces of the transcoder: track input and MIDI output.
// Depends on nothing.
interface hmp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       first_track;
    logic       loop_track;

    modport source (output valid, command, data_byte, first_track, loop_track,
                    input ready);
    modport sink   (input valid, command, data_byte, first_track, loop_track,
                    output ready);
endinterface

interface hmp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       delta_overflow;

    modport source (output valid, out_byte, last, delta_overflow, input ready);
    modport sink   (input valid, out_byte, last, delta_overflow, output ready);
endinterface

>>> sv/hmp_tempo_div.sv
// Restoring divider for the tempo: 120000000 over the header tempo word.
// One quotient bit per cycle. Depends on hmp_pkg.
module hmp_tempo_div
    import hmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [23:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [31:0]           r_rem;
    logic [DIVIDEND_W-1:0] r_q;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[DIVIDEND_W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
        n_rem = ge ? diff[31:0] : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= TEMPO_DIVIDEND;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q[23:0];

endmodule

>>> sv/hmp_datapath.sv
// Datapath of the transcoder: parser state, delta stack, burst source,
// tempo register and quotient, output register. Depends on hmp_pkg, hmp_tempo_div.
module hmp_datapath
    import hmp_pkg::*;
#(
    parameter int unsigned MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_track,
    input  logic        i_loop_track,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_out_delta_overflow
);

    localparam int unsigned CAP = (MAX_DELTA_BYTES > 7) ? 7 :
                                  ((MAX_DELTA_BYTES < 1) ? 1 : MAX_DELTA_BYTES);
    localparam int unsigned CW  = $clog2(CAP + 1);

    typedef enum logic [2:0] {
        PH_DELTA, PH_EVENT, PH_COPY, PH_SYSEX,
        PH_META_TYPE, PH_META_LEN, PH_CTRL_NUM, PH_CTRL_VAL
    } t_phase;

    typedef enum logic [1:0] {SRC_TEMPO, SRC_LIST, SRC_DELTA} t_src;

    logic [31:0]  r_cfg_tempo;
    t_phase       r_phase, n_phase;
    logic [6:0]   r_stack [CAP];
    logic [CW-1:0] r_dcount, n_dcount;
    logic [7:0]   r_rs, n_rs;
    logic [7:0]   r_copy, n_copy;
    logic [7:0]   r_held, n_held;
    logic         r_loop, n_loop;
    t_src         r_src, n_src;
    logic [2:0]   r_idx, n_idx;
    logic [7:0]   r_b0, n_b0;
    logic [7:0]   r_b1, n_b1;
    logic         r_dflag, n_dflag;
    logic [23:0]  r_quot, n_quot;
    logic         r_ov;
    logic [7:0]   r_obyte;
    logic         r_olast;
    logic         r_oflag;

    logic [BURST_W-1:0] len;
    logic         div_req;
    logic         push;
    logic         do_delta;
    logic         copy_go;
    logic [7:0]   copy_len;
    logic [1:0]   rs_len;
    logic [CW-1:0] d_base, d_new;
    logic         d_term;
    logic         div_done;
    logic [23:0]  div_quot;
    logic [7:0]   emit_byte;
    logic         emit_flag;

    hmp_tempo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load & div_req),
        .i_divisor  (r_cfg_tempo),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Delta push: a delta ends on a terminator or when the stack is full.
    always_comb begin
        d_base = (r_dcount >= CW'(CAP)) ? '0 : r_dcount;
        d_new  = d_base + 1'b1;
        d_term = i_data_byte[7] || (d_new == CW'(CAP));
        rs_len = cmd_len(r_rs[6:4]);
    end

    always_comb begin
        n_phase  = r_phase;
        n_dcount = r_dcount;
        n_rs     = r_rs;
        n_copy   = r_copy;
        n_held   = r_held;
        n_loop   = r_loop;
        n_src    = r_src;
        n_idx    = r_idx;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_dflag  = r_dflag;
        n_quot   = r_quot;
        len      = '0;
        div_req  = 1'b0;
        push     = 1'b0;
        do_delta = 1'b0;
        copy_go  = 1'b0;
        copy_len = '0;
        if (i_cmd.load) begin
            n_idx = '0;
            if (!i_command) begin
                n_rs     = '0;
                n_phase  = PH_DELTA;
                n_dcount = '0;
                n_copy   = '0;
                n_held   = '0;
                n_loop   = i_loop_track;
                if (i_first_track) begin
                    n_src = SRC_TEMPO;
                    len   = TEMPO_BURST_LEN;
                    if (r_cfg_tempo == '0) begin
                        n_quot = TEMPO_ZERO_DIV;
                    end else begin
                        div_req = 1'b1;
                    end
                end
            end else begin
                n_src = SRC_LIST;
                n_b0  = i_data_byte;
                unique case (r_phase)
                    PH_DELTA: begin
                        do_delta = 1'b1;
                    end
                    PH_EVENT: begin
                        if (i_data_byte[7]) begin
                            len  = BURST_W'(1);
                            n_rs = i_data_byte;
                            if (i_data_byte[7:4] == STATUS_HI_SYSTEM) begin
                                if (i_data_byte[3:0] == SYS_LO_SYSEX) begin
                                    n_phase = PH_SYSEX;
                                end else if (i_data_byte[3:0] == SYS_LO_META) begin
                                    n_phase = PH_META_TYPE;
                                end else begin
                                    copy_go  = 1'b1;
                                    copy_len = 8'(syscom_len(i_data_byte[3:0]));
                                end
                            end else if (i_data_byte[7:4] == STATUS_HI_CTRL) begin
                                n_phase = PH_CTRL_NUM;
                            end else begin
                                copy_go  = 1'b1;
                                copy_len = 8'(cmd_len(i_data_byte[6:4]));
                            end
                        end else if (rs_len == 2'd0) begin
                            // A system running status has no data length: this
                            // byte opens the next delta time.
                            do_delta = 1'b1;
                        end else begin
                            len      = BURST_W'(1);
                            copy_go  = 1'b1;
                            copy_len = 8'(rs_len - 2'd1);
                        end
                    end
                    PH_COPY: begin
                        len    = BURST_W'(1);
                        n_copy = (r_copy != '0) ? r_copy - 8'd1 : r_copy;
                        if (n_copy == '0) begin
                            n_phase = PH_DELTA;
                        end
                    end
                    PH_SYSEX: begin
                        len = BURST_W'(1);
                        if (i_data_byte[7]) begin
                            n_phase = PH_DELTA;
                        end
                    end
                    PH_META_TYPE: begin
                        len     = BURST_W'(1);
                        n_phase = PH_META_LEN;
                    end
                    PH_META_LEN: begin
                        len      = BURST_W'(1);
                        copy_go  = 1'b1;
                        copy_len = i_data_byte;
                    end
                    PH_CTRL_NUM: begin
                        if (i_data_byte >= CTRL_MAP_LO && i_data_byte <= CTRL_MAP_HI) begin
                            n_held  = i_data_byte;
                            n_phase = PH_CTRL_VAL;
                        end else begin
                            len      = BURST_W'(1);
                            copy_go  = 1'b1;
                            copy_len = 8'd1;
                        end
                    end
                    PH_CTRL_VAL: begin
                        len     = BURST_W'(2);
                        n_phase = PH_DELTA;
                        if (r_loop && r_held == CTRL_LOOP_START) begin
                            n_b0 = EMIDI_LOOP_START;
                            n_b1 = {1'b0, i_data_byte[6:0]};
                        end else if (r_loop && r_held == CTRL_LOOP_END) begin
                            n_b0 = EMIDI_LOOP_END;
                            n_b1 = CTRL_MAX_VALUE;
                        end else begin
                            n_b0 = CTRL_NEUTRAL;
                            n_b1 = CTRL_ZERO_VALUE;
                        end
                    end
                endcase
                if (copy_go) begin
                    n_copy  = copy_len;
                    n_phase = (copy_len != '0) ? PH_COPY : PH_DELTA;
                end
                if (do_delta) begin
                    push     = 1'b1;
                    n_dcount = d_new;
                    if (d_term) begin
                        n_phase = PH_EVENT;
                        n_src   = SRC_DELTA;
                        n_dflag = ~i_data_byte[7];
                        len     = BURST_W'(d_new);
                    end else begin
                        n_phase = PH_DELTA;
                    end
                end
            end
        end else if (i_cmd.emit) begin
            n_idx = r_idx + 3'd1;
            if (r_src == SRC_DELTA) begin
                n_dcount = r_dcount - 1'b1;
            end
        end
        if (div_done) begin
            n_quot = div_quot;
        end
    end

    // Next burst byte. Delta groups leave newest first; every group but the
    // last carries the continuation bit.
    always_comb begin
        emit_flag = 1'b0;
        case (r_src)
            SRC_TEMPO: begin
                case (r_idx)
                    3'd0:    emit_byte = DELTA_ZERO;
                    3'd1:    emit_byte = META_STATUS;
                    3'd2:    emit_byte = META_TEMPO;
                    3'd3:    emit_byte = META_TEMPO_LEN;
                    3'd4:    emit_byte = r_quot[23:16];
                    3'd5:    emit_byte = r_quot[15:8];
                    default: emit_byte = r_quot[7:0];
                endcase
            end
            SRC_DELTA: begin
                emit_byte = {~i_cmd.last, r_stack[0]};
                emit_flag = r_dflag;
            end
            default: begin
                emit_byte = (r_idx == 3'd0) ? r_b0 : r_b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tempo <= HEADER_TEMPO_RESET;
            r_phase     <= PH_DELTA;
            r_dcount    <= '0;
            r_rs        <= '0;
            r_copy      <= '0;
            r_held      <= '0;
            r_loop      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_tempo <= i_cfg_wdata;
            end
            r_phase  <= n_phase;
            r_dcount <= n_dcount;
            r_rs     <= n_rs;
            r_copy   <= n_copy;
            r_held   <= n_held;
            r_loop   <= n_loop;
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_idx   <= n_idx;
        r_b0    <= n_b0;
        r_b1    <= n_b1;
        r_dflag <= n_dflag;
        r_quot  <= n_quot;
        if (push) begin
            r_stack[0] <= i_data_byte[6:0];
            for (int i = 1; i < CAP; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.emit && r_src == SRC_DELTA) begin
            for (int i = 0; i < CAP - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
            r_stack[CAP-1] <= '0;
        end
        if (i_cmd.emit) begin
            r_obyte <= emit_byte;
            r_olast <= i_cmd.last;
            r_oflag <= emit_flag;
        end
    end

    assign o_status.burst_len = len;
    assign o_status.div_req   = div_req;
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = ~r_ov | i_out_ready;

    assign o_out_valid          = r_ov;
    assign o_out_byte           = r_obyte;
    assign o_out_last           = r_olast;
    assign o_out_delta_overflow = r_oflag;

endmodule

>>> sv/hmp_ctrl.sv
// Controller of the transcoder: accepts input items, waits on the tempo
// division and sequences the output burst. Depends on hmp_pkg.
module hmp_ctrl
    import hmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} t_state;

    t_state             r_state;
    logic [BURST_W-1:0] r_left;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.emit = (r_state == S_EMIT) && i_status.out_free;
        o_cmd.last = (r_left == BURST_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_left <= i_status.burst_len;
                        if (i_status.div_req) begin
                            r_state <= S_DIV;
                        end else if (i_status.burst_len != '0) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_cmd.emit) begin
                        r_left <= r_left - 1'b1;
                        if (o_cmd.last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/hmp_track_to_midi_transcoder.sv
// Top level of the HMP track to Standard MIDI transcoder.
// Depends on hmp_pkg, hmp_if, hmp_ctrl, hmp_datapath, hmp_tempo_div.
//
//   Channel   Direction  Handshake      Contents
//   i_in      in         valid/ready    command, data_byte, first_track, loop_track
//   o_out     out        valid/ready    out_byte, last, delta_overflow
//   i_cfg_*   in         write enable   header_tempo (32 bits)
//
// After an input transfer is taken, its output bytes leave the output register
// one per cycle while the sink is ready. A track start with the tempo event
// waits on the bit-serial tempo divider unless the header tempo is zero.
// Input is taken again once the last byte sits in the output register.
// Reset is synchronous and needs no clearing pass.
module hmp_track_to_midi_transcoder
    import hmp_pkg::*;
#(
    parameter int unsigned MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmp_in_if.sink      i_in,
    hmp_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // The controller owns the input handshake and the burst count.
    hmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // The datapath parses each byte on a transfer and drives the output register.
    hmp_datapath #(
        .MAX_DELTA_BYTES (MAX_DELTA_BYTES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_command            (i_in.command),
        .i_data_byte          (i_in.data_byte),
        .i_first_track        (i_in.first_track),
        .i_loop_track         (i_in.loop_track),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_out_byte           (o_out.out_byte),
        .o_out_last           (o_out.last),
        .o_out_delta_overflow (o_out.delta_overflow)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of hmp_track_to_midi_transcoder: directed and random HMP track bytes.
// Depends on hmp_pkg, the channel interfaces in hmp_if and the transcoder RTL.
module testbench;
    import hmp_pkg::*;

    // A delta time is cut at this many groups; one step never gives more than seven bytes.
    localparam int DELTA_CAP    = (MAX_DELTA_BYTES_DEF > 7) ? 7 : MAX_DELTA_BYTES_DEF;
    // Cycles without any transfer before the run is declared hung. The slowest honest
    // stall is a tempo division plus a long sink stall, well below this.
    localparam int STALL_LIMIT  = 3000;
    // Cycles allowed after the last expected byte, so that items with no output settle.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 130;
    localparam int RANDOM_PHASES = 5;

    localparam logic       CMD_TRACK_START = 1'b0;
    localparam logic       CMD_DATA_BYTE   = 1'b1;
    localparam logic [7:0] SYSEX_END       = 8'hF7;
    localparam logic [7:0] DELTA_LAST      = 8'h80;

    // Parser states of the transcoder as the predictor sees them.
    typedef enum logic [3:0] {
        ST_DELTA,
        ST_EVENT,
        ST_COPY,
        ST_SYSEX,
        ST_META_TYPE,
        ST_META_LEN,
        ST_CTRL_NUM,
        ST_CTRL_VAL
    } t_parse_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       delta_overflow;
    } t_midi_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    hmp_in_if  in_if ();
    hmp_out_if out_if ();

    hmp_track_to_midi_transcoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the transcoder state, advanced at every accepted input transfer.
    t_parse_state parse_state;
    logic [6:0]   delta_groups [DELTA_CAP];
    int           delta_count;
    logic [7:0]   running_status;
    logic [7:0]   copy_left;
    logic [7:0]   held_ctrl;
    logic         loop_mapping;
    logic [31:0]  tempo_word;

    // MIDI bytes still owed by the block, oldest first, and the bytes of the current item.
    t_midi_byte midi_expected [$];
    t_midi_byte burst [$];

    int mismatch_count = 0;
    int accepted_items = 0;
    // When set, neither side of the block idles.
    bit no_idle = 1'b0;

    // Adds one byte to the burst of the item under prediction.
    function automatic void emit_byte(input logic [7:0] value, input logic cut);
        t_midi_byte mb;
        if (burst.size() < 7) begin
            mb.out_byte       = value;
            mb.last           = 1'b0;
            mb.delta_overflow = cut;
            burst.push_back(mb);
        end
    endfunction

    // Data length of a channel status, indexed by status bits 6:4; -1 means none.
    function automatic int channel_data_len(input logic [2:0] idx);
        case (idx)
            3'd4, 3'd5: return 1;
            3'd7:       return -1;
            default:    return 2;
        endcase
    endfunction

    // Data length of a system common message by its low nibble.
    function automatic int system_data_len(input logic [3:0] lo);
        case (lo)
            4'h2:    return 2;
            4'h3:    return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void begin_copy(input int len);
        if (len > 0) begin
            copy_left   = len[7:0];
            parse_state = ST_COPY;
        end else begin
            copy_left   = 8'd0;
            parse_state = ST_DELTA;
        end
    endfunction

    // Collects the little-endian delta groups and, once the delta ends, sends them
    // out most significant group first with the continuation bit on all but the last.
    function automatic void take_delta_byte(input logic [7:0] b);
        logic cut;
        if (delta_count >= DELTA_CAP) delta_count = 0;
        delta_groups[delta_count] = b[6:0];
        delta_count++;
        if (!b[7] && delta_count < DELTA_CAP) return;
        // A delta that ran out of room without a terminator is flagged on every byte.
        cut = !b[7];
        while (delta_count > 0) begin
            delta_count--;
            emit_byte({delta_count != 0, delta_groups[delta_count]}, cut);
        end
        parse_state = ST_EVENT;
    endfunction

    function automatic void take_event_byte(input logic [7:0] b);
        int len;
        if (b[7]) begin
            emit_byte(b, 1'b0);
            running_status = b;
            if (b[7:4] == STATUS_HI_SYSTEM) begin
                if (b[3:0] == SYS_LO_SYSEX) parse_state = ST_SYSEX;
                else if (b[3:0] == SYS_LO_META) parse_state = ST_META_TYPE;
                else begin_copy(system_data_len(b[3:0]));
            end else if (b[7:4] == STATUS_HI_CTRL) begin
                parse_state = ST_CTRL_NUM;
            end else begin
                begin_copy(channel_data_len(b[6:4]));
            end
        end else begin
            // Running status. A system status has no data length, so the byte is
            // really the first group of the next delta time.
            len = channel_data_len(running_status[6:4]);
            if (len <= 0) begin
                parse_state = ST_DELTA;
                take_delta_byte(b);
            end else begin
                emit_byte(b, 1'b0);
                begin_copy(len - 1);
            end
        end
    endfunction

    // Works out the MIDI bytes that one accepted input item causes and queues them.
    function automatic void transcode_item(input logic cmd, input logic [7:0] b,
                                           input logic first, input logic loop);
        logic [23:0] tempo;
        t_midi_byte  tail;
        burst.delete();
        if (cmd == CMD_TRACK_START) begin
            running_status = 8'd0;
            parse_state    = ST_DELTA;
            delta_count    = 0;
            copy_left      = 8'd0;
            held_ctrl      = 8'd0;
            loop_mapping   = loop;
            if (first) begin
                tempo = (tempo_word == 32'd0) ? TEMPO_ZERO_DIV
                                              : 24'(32'(TEMPO_DIVIDEND) / tempo_word);
                emit_byte(DELTA_ZERO, 1'b0);
                emit_byte(META_STATUS, 1'b0);
                emit_byte(META_TEMPO, 1'b0);
                emit_byte(META_TEMPO_LEN, 1'b0);
                emit_byte(tempo[23:16], 1'b0);
                emit_byte(tempo[15:8], 1'b0);
                emit_byte(tempo[7:0], 1'b0);
            end
        end else begin
            case (parse_state)
                ST_DELTA: take_delta_byte(b);
                ST_EVENT: take_event_byte(b);
                ST_COPY: begin
                    // Copied blindly, status bytes included.
                    emit_byte(b, 1'b0);
                    if (copy_left > 0) copy_left--;
                    if (copy_left == 0) parse_state = ST_DELTA;
                end
                ST_SYSEX: begin
                    emit_byte(b, 1'b0);
                    if (b[7] || b == SYSEX_END) parse_state = ST_DELTA;
                end
                ST_META_TYPE: begin
                    emit_byte(b, 1'b0);
                    parse_state = ST_META_LEN;
                end
                ST_META_LEN: begin
                    emit_byte(b, 1'b0);
                    begin_copy(int'(b));
                end
                ST_CTRL_NUM: begin
                    // Controllers in the remapped range are held back until their value.
                    if (b >= CTRL_MAP_LO && b <= CTRL_MAP_HI) begin
                        held_ctrl   = b;
                        parse_state = ST_CTRL_VAL;
                    end else begin
                        emit_byte(b, 1'b0);
                        begin_copy(1);
                    end
                end
                ST_CTRL_VAL: begin
                    if (loop_mapping && held_ctrl == CTRL_LOOP_START) begin
                        emit_byte(EMIDI_LOOP_START, 1'b0);
                        emit_byte({1'b0, b[6:0]}, 1'b0);
                    end else if (loop_mapping && held_ctrl == CTRL_LOOP_END) begin
                        emit_byte(EMIDI_LOOP_END, 1'b0);
                        emit_byte(CTRL_MAX_VALUE, 1'b0);
                    end else begin
                        emit_byte(CTRL_NEUTRAL, 1'b0);
                        emit_byte(CTRL_ZERO_VALUE, 1'b0);
                    end
                    parse_state = ST_DELTA;
                end
                default: parse_state = ST_DELTA;
            endcase
        end
        if (burst.size() > 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i]) midi_expected.push_back(burst[i]);
    endfunction

    // Offers one item and returns at the edge of its transfer. The valid stays high,
    // so a following item goes out back to back unless a gap is drawn.
    task automatic send_item(input logic cmd, input logic [7:0] b,
                             input logic first, input logic loop);
        if (!no_idle && $urandom_range(99) < 20) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 20);
        end
        in_if.valid       <= 1'b1;
        in_if.command     <= cmd;
        in_if.data_byte   <= b;
        in_if.first_track <= first;
        in_if.loop_track  <= loop;
        do @(posedge i_clk); while (!in_if.ready);
        transcode_item(cmd, b, first, loop);
        accepted_items++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(CMD_DATA_BYTE, b, 1'($urandom), 1'($urandom));
    endtask

    task automatic track_start(input logic first, input logic loop);
        send_item(CMD_TRACK_START, 8'($urandom), first, loop);
    endtask

    // Holds the sender off until every owed byte has come, then lets the block settle.
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (midi_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is only written while the block is idle.
    task automatic write_tempo(input logic [31:0] value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        tempo_word  = value;
    endtask

    // Mostly seven-bit data, now and then a byte with bit 7 set.
    function automatic logic [7:0] rand_data();
        return ($urandom_range(7) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
    endfunction

    task automatic send_delta();
        int   groups;
        int   g;
        logic cut;
        cut    = ($urandom_range(9) == 0);
        groups = cut ? DELTA_CAP : $urandom_range(1, DELTA_CAP);
        for (g = 1; g <= groups; g++) begin
            send_data({(g == groups) && !cut, 7'($urandom)});
        end
    endtask

    // One random piece of a track: mostly a delta time and a well-formed event,
    // sometimes a new track or a stray byte that throws the parser off.
    task automatic send_random_event();
        int         pick;
        int         count;
        logic [7:0] status;
        logic [7:0] number;
        logic [3:0] lo;
        pick = $urandom_range(99);
        if (pick < 6) begin
            track_start($urandom_range(3) == 0, 1'($urandom));
        end else if (pick < 14) begin
            send_data(8'($urandom));
        end else begin
            send_delta();
            case ($urandom_range(9))
                0, 1, 2: begin
                    status = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
                    send_data(status);
                    count = (status[7:4] == STATUS_HI_CTRL) ? 2 : channel_data_len(status[6:4]);
                    repeat (count) send_data(rand_data());
                end
                3: begin
                    repeat ($urandom_range(1, 2)) send_data(rand_data());
                end
                4, 5: begin
                    case ($urandom_range(3))
                        0:       number = CTRL_LOOP_START;
                        1:       number = CTRL_LOOP_END;
                        2:       number = 8'($urandom_range(102, 119));
                        default: number = rand_data();
                    endcase
                    send_data({STATUS_HI_CTRL, 4'($urandom)});
                    send_data(number);
                    send_data(rand_data());
                end
                6: begin
                    send_data({STATUS_HI_SYSTEM, SYS_LO_SYSEX});
                    repeat ($urandom_range(3)) send_data({1'b0, 7'($urandom)});
                    send_data(($urandom_range(3) == 0) ? {1'b1, 7'($urandom)} : SYSEX_END);
                end
                7: begin
                    count = $urandom_range(3);
                    send_data({STATUS_HI_SYSTEM, SYS_LO_META});
                    send_data({1'b0, 7'($urandom)});
                    send_data(8'(count));
                    repeat (count) send_data(8'($urandom));
                end
                8: begin
                    lo = 4'($urandom_range(1, 14));
                    send_data({STATUS_HI_SYSTEM, lo});
                    repeat (system_data_len(lo)) send_data(rand_data());
                end
                default: send_data({1'b0, 7'($urandom)});
            endcase
        end
    endtask

    // Tempo meta event at the reset tempo, at a zero tempo word and at the smallest divisor.
    task automatic test_tempo_event();
        track_start(1'b1, 1'b0);
        write_tempo(32'd0);
        track_start(1'b1, 1'b0);
        write_tempo(32'd1);
        track_start(1'b1, 1'b1);
    endtask

    // An overlong delta with all groups full, then data bytes before any status,
    // which are taken as a two-byte command.
    task automatic test_delta_times();
        repeat (DELTA_CAP) send_data(8'h7F);
        send_data(8'h22);
        send_data(8'h33);
    endtask

    // Loop start on the loop track; the value loses bit 7.
    task automatic test_loop_controllers();
        send_data(DELTA_LAST);
        send_data({STATUS_HI_CTRL, 4'h0});
        send_data(CTRL_LOOP_START);
        send_data(8'hFF);
    endtask

    // Two-group delta, a sysex, a system common message whose data byte is a status
    // copied blindly, and a data byte under a system running status that opens a delta.
    task automatic test_system_messages();
        send_data(8'h01);
        send_data(8'h82);
        send_data({STATUS_HI_SYSTEM, SYS_LO_SYSEX});
        send_data(SYSEX_END);
        send_data(DELTA_LAST);
        send_data(8'hF3);
        send_data(8'h95);
        send_data(DELTA_LAST);
        send_data(8'h10);
        send_data(DELTA_LAST);
    endtask

    // Off the loop track even a loop controller turns into the neutral pair.
    task automatic test_plain_track_controllers();
        track_start(1'b0, 1'b0);
        send_data(DELTA_LAST);
        send_data({STATUS_HI_CTRL, 4'hF});
        send_data(CTRL_LOOP_END);
        send_data(8'h40);
    endtask

    // Random tracks in several phases, each under its own tempo word. One phase runs
    // without any idling, and in another the sender may wait for the output to drain near its end.
    task automatic test_random_stream();
        int          phase_idx;
        int          phase_end;
        logic [31:0] tempo;
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
            case (phase_idx)
                0:       tempo = $urandom;
                1:       tempo = $urandom_range(1, 2000);
                2:       tempo = 32'hFFFF_FFFF;
                3:       tempo = 32'd0;
                default: tempo = $urandom_range(1, 120000000);
            endcase
            write_tempo(tempo);
            no_idle   = (phase_idx == 2);
            phase_end = accepted_items + RANDOM_ITEMS / RANDOM_PHASES;
            track_start(1'b1, 1'($urandom));
            while (accepted_items < phase_end) begin
                send_random_event();
                if (phase_idx == 3 && accepted_items >= phase_end - RANDOM_ITEMS / 10 &&
                    accepted_items < phase_end - RANDOM_ITEMS / 10 + 4) begin
                    wait_drain();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Output side: each byte that leaves the block is checked against the oldest
    // expectation, and the ready is redrawn for the next cycle.
    always @(posedge i_clk) begin : check_output
        t_midi_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (midi_expected.size() == 0) begin
                $error("out_byte: expected none, actual %02h", out_if.out_byte);
                mismatch_count++;
            end else begin
                want = midi_expected.pop_front();
                if (out_if.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h", want.out_byte,
                           out_if.out_byte);
                    mismatch_count++;
                end
                if (out_if.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, out_if.last);
                    mismatch_count++;
                end
                if (out_if.delta_overflow !== want.delta_overflow) begin
                    $error("delta_overflow: expected %0b, actual %0b", want.delta_overflow,
                           out_if.delta_overflow);
                    mismatch_count++;
                end
            end
        end
        out_if.ready <= no_idle || ($urandom_range(99) >= 20);
    end

    // Ends a hung run: too many cycles in a row without a transfer on either channel.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 32'd0;
        in_if.valid       <= 1'b0;
        in_if.command     <= CMD_TRACK_START;
        in_if.data_byte   <= 8'd0;
        in_if.first_track <= 1'b0;
        in_if.loop_track  <= 1'b0;

        // The shadow state starts where the block comes out of reset.
        tempo_word     = HEADER_TEMPO_RESET;
        parse_state    = ST_DELTA;
        delta_count    = 0;
        running_status = 8'd0;
        copy_left      = 8'd0;
        held_ctrl      = 8'd0;
        loop_mapping   = 1'b0;
        foreach (delta_groups[i]) delta_groups[i] = 7'd0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tempo_event();
        test_delta_times();
        test_loop_controllers();
        test_system_messages();
        test_plain_track_controllers();
        test_random_stream();

        // Let every owed byte arrive, then watch a little longer for strays.
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/hmp_pkg.sv
sv/hmp_if.sv
sv/hmp_tempo_div.sv
sv/hmp_datapath.sv
sv/hmp_ctrl.sv
sv/hmp_track_to_midi_transcoder.sv
verif/testbench.sv
